[rtl/pid_duty_regulator_defines.svh]
// Assertion macros shared by the regulator RTL.
// No dependencies; expects clk and rst in the including module.
`ifndef PID_DUTY_REGULATOR_DEFINES_SVH
`define PID_DUTY_REGULATOR_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define PIDR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define PIDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pidr_pkg.sv]
// Shared widths, register codes and bundle types for the PID duty regulator.
// No dependencies.
`default_nettype none

package pidr_pkg;

  localparam int TEMP_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int DUTY_W    = 16;
  localparam int CTL_W     = 32;
  localparam int ERR_W     = TEMP_W + 1;            // exact setpoint - sample
  localparam int PROD_W    = GAIN_W + ERR_W;        // gain * error
  localparam int DIV_SHIFT = 12;                    // gains are in 1/4096
  localparam int SCL_W     = PROD_W - DIV_SHIFT;    // scaled term
  localparam int PD_W      = SCL_W + 1;             // P + D
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [TEMP_W-1:0] SETPOINT_RESET = 16'd448;
  localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 16'd999;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_SETPOINT = 3'd3,
    REG_DUTY_MIN = 3'd4,
    REG_DUTY_MAX = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [TEMP_W-1:0] setpoint;
    logic        [DUTY_W-1:0] duty_min;
    logic        [DUTY_W-1:0] duty_max;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] delta;
  } diff_t;

  typedef struct packed {
    logic signed [SCL_W-1:0] i_term;
    logic signed [PD_W-1:0]  pd_term;
  } terms_t;

endpackage

`default_nettype wire

[rtl/pidr_front.sv]
// Input stage: sample register, previous-sample tracking, error and delta.
// Depends on pidr_pkg and pid_duty_regulator_defines.svh.
`default_nettype none
`include "pid_duty_regulator_defines.svh"

module pidr_front import pidr_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cfg_t                     cfg,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [TEMP_W-1:0] temperature,
  output logic                          diff_valid,
  input  wire logic                     diff_ready,
  output diff_t                         diff
);

  logic signed [TEMP_W-1:0] previous_temperature;
  logic                     have_previous;
  logic                     s1_valid;
  diff_t                    s1_diff;
  diff_t                    diff_next;
  logic signed [TEMP_W-1:0] prev_sel;
  logic                     take;

  assign in_stall = s1_valid && !diff_ready;
  assign take     = in_valid && !in_stall;

  // first sample stands in for its own predecessor
  assign prev_sel = have_previous ? previous_temperature : temperature;

  always_comb begin
    diff_next.err   = ERR_W'(cfg.setpoint) - ERR_W'(temperature);
    diff_next.delta = ERR_W'(prev_sel) - ERR_W'(temperature);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid             <= 1'b0;
      have_previous        <= 1'b0;
      previous_temperature <= '0;
    end else begin
      if (take) begin
        s1_valid             <= 1'b1;
        have_previous        <= 1'b1;
        previous_temperature <= temperature;
      end else if (diff_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_diff <= diff_next;
    end
  end

  assign diff_valid = s1_valid;
  assign diff       = s1_diff;

  `PIDR_ASSERT_NEXT(a_first_delta_zero, take && !have_previous, s1_diff.delta == '0, "first sample gave nonzero delta")

endmodule

`default_nettype wire

[rtl/pidr_gain.sv]
// Gain stages: product register, then truncating 1/4096 scale and P+D sum.
// Depends on pidr_pkg.
`default_nettype none

module pidr_gain import pidr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  diff_valid,
  output logic       diff_ready,
  input  wire diff_t diff,
  output logic       terms_valid,
  input  wire logic  terms_ready,
  output terms_t     terms
);

  logic                     s2_valid;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic                     s3_valid;
  terms_t                   s3_terms;
  terms_t                   terms_next;
  logic                     s2_ready;
  logic                     s3_ready;
  logic                     s2_take;
  logic                     s3_take;
  logic signed [SCL_W-1:0]  scl_p;
  logic signed [SCL_W-1:0]  scl_d;

  // divide by 2^DIV_SHIFT, rounding toward zero
  function automatic logic signed [SCL_W-1:0] scale_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    biased = p + {{(PROD_W-DIV_SHIFT){1'b0}}, {DIV_SHIFT{p[PROD_W-1]}}};
    return SCL_W'(biased >>> DIV_SHIFT);
  endfunction

  assign s3_ready   = !s3_valid || terms_ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign diff_ready = s2_ready;
  assign s2_take    = diff_valid && s2_ready;
  assign s3_take    = s2_valid && s3_ready;

  always_comb begin
    scl_p              = scale_trunc(prod_p);
    scl_d              = scale_trunc(prod_d);
    terms_next.i_term  = scale_trunc(prod_i);
    terms_next.pd_term = PD_W'(scl_p) + PD_W'(scl_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s2_take) begin
        s2_valid <= 1'b1;
      end else if (s3_ready) begin
        s2_valid <= 1'b0;
      end
      if (s3_take) begin
        s3_valid <= 1'b1;
      end else if (terms_ready) begin
        s3_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      prod_p <= PROD_W'(cfg.gain_p) * PROD_W'(diff.err);
      prod_i <= PROD_W'(cfg.gain_i) * PROD_W'(diff.err);
      prod_d <= PROD_W'(cfg.gain_d) * PROD_W'(diff.delta);
    end
    if (s3_take) begin
      s3_terms <= terms_next;
    end
  end

  assign terms_valid = s3_valid;
  assign terms       = s3_terms;

endmodule

`default_nettype wire

[rtl/pidr_accum.sv]
// Result stage: saturating integral, control sum, clamped duty, output register.
// Depends on pidr_pkg and pid_duty_regulator_defines.svh.
`default_nettype none
`include "pid_duty_regulator_defines.svh"

module pidr_accum import pidr_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    cfg,
  input  wire logic                    terms_valid,
  output logic                         terms_ready,
  input  wire terms_t                  terms,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic        [DUTY_W-1:0]     duty,
  output logic signed [CTL_W-1:0]      control_value
);

  localparam int SUM_W = CTL_W + 2;

  logic signed [CTL_W-1:0] integral_sum;
  logic        [DUTY_W-1:0] current_duty;
  logic signed [CTL_W-1:0] ctl_reg;
  logic                    res_valid;
  logic                    take;
  logic signed [CTL_W:0]   integ_wide;
  logic signed [CTL_W-1:0] integral_sum_next;
  logic signed [CTL_W:0]   ctl_wide;
  logic signed [CTL_W-1:0] ctl_next;
  logic signed [SUM_W-1:0] duty_sum;
  logic signed [SUM_W-1:0] lim_max;
  logic signed [SUM_W-1:0] lim_min;
  logic signed [SUM_W-1:0] clamped;
  logic        [DUTY_W-1:0] current_duty_next;

  function automatic logic signed [CTL_W-1:0] sat_ctl(input logic signed [CTL_W:0] v);
    if (v[CTL_W] != v[CTL_W-1]) begin
      return v[CTL_W] ? {1'b1, {(CTL_W-1){1'b0}}} : {1'b0, {(CTL_W-1){1'b1}}};
    end
    return v[CTL_W-1:0];
  endfunction

  assign terms_ready = !res_valid || !out_stall;
  assign take        = terms_valid && terms_ready;

  always_comb begin
    integ_wide        = (CTL_W+1)'(integral_sum) + (CTL_W+1)'(terms.i_term);
    integral_sum_next = sat_ctl(integ_wide);
    ctl_wide          = (CTL_W+1)'(integral_sum_next) + (CTL_W+1)'(terms.pd_term);
    ctl_next          = sat_ctl(ctl_wide);
    duty_sum          = $signed({{(SUM_W-DUTY_W){1'b0}}, current_duty}) + SUM_W'(ctl_next);
    lim_max           = $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.duty_max});
    lim_min           = $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.duty_min});
    // upper clamp first, lower last: crossed limits settle on duty_min
    clamped           = (duty_sum > lim_max) ? lim_max : duty_sum;
    if (clamped < lim_min) begin
      clamped = lim_min;
    end
    current_duty_next = clamped[DUTY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      integral_sum <= '0;
      current_duty <= '0;
    end else begin
      if (take) begin
        res_valid    <= 1'b1;
        integral_sum <= integral_sum_next;
        current_duty <= current_duty_next;
      end else if (!out_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_reg <= ctl_next;
    end
  end

  assign out_valid     = res_valid;
  assign duty          = current_duty;
  assign control_value = ctl_reg;

  `PIDR_ASSERT_NEXT(a_duty_in_limits, take && (cfg.duty_min <= cfg.duty_max), (duty >= $past(cfg.duty_min)) && (duty <= $past(cfg.duty_max)), "duty outside limits")
  `PIDR_ASSERT_NEXT(a_duty_crossed, take && (cfg.duty_min > cfg.duty_max), duty == $past(cfg.duty_min), "crossed limits did not give duty_min")

endmodule

`default_nettype wire

[rtl/pid_duty_regulator.sv]
// Top level of the PID duty regulator: configuration registers and the pipeline.
// Depends on pidr_pkg, pidr_front, pidr_gain, pidr_accum and the defines header.
//
// One channel of a PID temperature regulator driving a PWM duty. Each input beat
// is a signed temperature sample in 1/16 degree units; each sample yields exactly
// one output beat with the new duty (clamped to duty_min..duty_max, the upper
// limit applied first) and the control value P + D + integral, saturated to 32
// bits. P and I act on setpoint minus sample, D on previous minus current sample
// (zero on the first sample after reset); every gain product is divided by 4096
// rounding toward zero and the integral saturates at the 32-bit bounds. The block
// is a four-stage pipeline (sample/difference register, product register, scaled
// term register, result register) and accepts one sample per clock while
// in_stall is low. The rate is held by the result stage, where the integral and
// duty update feeds back on itself from one sample to the next. in_stall rises
// only when all four stages are full and the output is
// stalled. Configuration writes (cfg_index 0..5: gain_p, gain_i, gain_d,
// setpoint, duty_min, duty_max; other indexes ignored) are always taken and must
// be made while no sample is in flight.
`default_nettype none
`include "pid_duty_regulator_defines.svh"

module pid_duty_regulator import pidr_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic        [CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [CFG_DAT_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [TEMP_W-1:0]    temperature,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic             [DUTY_W-1:0]    duty,
  output logic signed      [CTL_W-1:0]     control_value
);

  cfg_t   cfg;
  logic   diff_valid;
  logic   diff_ready;
  diff_t  diff;
  logic   terms_valid;
  logic   terms_ready;
  terms_t terms;

  assign cfg_ready = 1'b1;

  // register file; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p   <= '0;
      cfg.gain_i   <= '0;
      cfg.gain_d   <= '0;
      cfg.setpoint <= SETPOINT_RESET;
      cfg.duty_min <= '0;
      cfg.duty_max <= DUTY_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_GAIN_P:   cfg.gain_p   <= cfg_data;
        REG_GAIN_I:   cfg.gain_i   <= cfg_data;
        REG_GAIN_D:   cfg.gain_d   <= cfg_data;
        REG_SETPOINT: cfg.setpoint <= cfg_data;
        REG_DUTY_MIN: cfg.duty_min <= cfg_data;
        REG_DUTY_MAX: cfg.duty_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pidr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .temperature (temperature),
    .diff_valid  (diff_valid),
    .diff_ready  (diff_ready),
    .diff        (diff)
  );

  pidr_gain u_gain (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .diff_valid  (diff_valid),
    .diff_ready  (diff_ready),
    .diff        (diff),
    .terms_valid (terms_valid),
    .terms_ready (terms_ready),
    .terms       (terms)
  );

  pidr_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .terms_valid   (terms_valid),
    .terms_ready   (terms_ready),
    .terms         (terms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .duty          (duty),
    .control_value (control_value)
  );

  // input backpressure only when the whole pipe is full behind a stalled output
  `PIDR_ASSERT_IMPL(a_stall_only_when_full, in_stall, out_valid && out_stall && diff_valid && terms_valid, "input stalled with room in pipeline")

endmodule

`default_nettype wire
